// ----- hdl/lru_key_value_cache_defines.svh -----
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion wrappers, compiled out under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_ALWAYS(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)
`define ASSERT_ALWAYS(label, clock, reset, cond, msg)
`endif
`endif

// ----- hdl/lkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Widths, codes, payload and control types shared by the cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 3;

  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
  localparam logic [0:0]       REG_CAPACITY = 1'b0;
  localparam logic [VAL_W-1:0] MISS_DATA    = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] data;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic resolve;
    logic update;
    logic load_rsp;
  } lkv_cmd_t;

  typedef struct packed {
    logic is_get;
  } lkv_sts_t;

endpackage

// ----- hdl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
//
//   port group  dir  handshake              beat
//   req         in   req_valid/req_ready    op, key, value
//   rsp         out  rsp_valid/rsp_ready    hit, data (get only)
//   apb         in   psel/penable/pwrite    capacity at address 0
//
// An item passes through accept, key compare, hit and slot resolve, then
// rank update with the value memory write or the registered value read.
// A get waits in reply while the previous result beat is still held.
// Reset is synchronous; it empties the store and sets capacity to 16.
// A capacity write also empties the store.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  lkv_cmd_t         cmd;
  lkv_sts_t         sts;
  logic             cfg_we;
  logic [CAP_W-1:0] capacity;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2:2] == REG_CAPACITY);
  assign prdata = (paddr[2:2] == REG_CAPACITY) ? APB_DW'(capacity) : '0;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkv_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[CAP_W-1:0]),
    .capacity  (capacity)
  );

endmodule

// ----- hdl/lkv_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lkv_ctrl.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences match, resolve and update steps and owns the result handshake.
// ----------------------------------------------------------------------------
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  lkv_sts_t sts,
  output lkv_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MATCH   = 5'b00010,
    S_RESOLVE = 5'b00100,
    S_UPDATE  = 5'b01000,
    S_REPLY   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!sts.is_get) begin
          state_next = S_IDLE;
        end else if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.load_rsp, rsp_free, "result overwritten while pending")
  `ASSERT_IMPLIES(a_reply_pending, clk, rst, state == S_REPLY, rsp_valid, "reply wait without pending beat")
  `ASSERT_IMPLIES(a_set_no_reply, clk, rst, cmd.update && !sts.is_get, !cmd.load_rsp, "set produced a result")

endmodule

// ----- hdl/lkv_dpath.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key compare row, age ranks, slot choice, value memory and result register.
// ----------------------------------------------------------------------------
module lkv_dpath
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lkv_cmd_t         cmd,
  output lkv_sts_t         sts,
  input  req_t             req,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output logic [CAP_W-1:0] capacity
);

  localparam int RW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [7:0] MAX_W8 = 8'(MAX_ENTRIES);

  req_t                   req_q;
  logic [KEY_W-1:0]       keys [MAX_ENTRIES];
  logic [RW-1:0]          rank [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [CW-1:0]          count;
  logic [MAX_ENTRIES-1:0] match;

  logic                   hit_q;
  logic [RW-1:0]          hit_idx_q;
  logic [RW-1:0]          hit_rank_q;
  logic                   evict_q;
  logic [MAX_ENTRIES-1:0] slot_oh_q;
  logic [RW-1:0]          slot_idx_q;
  logic                   slot_found_q;

  logic [MAX_ENTRIES-1:0] match_c;
  logic [RW-1:0]          hit_idx_c;
  logic [RW-1:0]          hit_rank_c;
  logic [CW-1:0]          eff_cap;
  logic                   evict_c;
  logic [RW-1:0]          last_rank;
  logic [MAX_ENTRIES-1:0] old_oh;
  logic [MAX_ENTRIES-1:0] free;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [MAX_ENTRIES-1:0] slot_oh_c;
  logic [RW-1:0]          slot_idx_c;

  logic                   is_set;
  logic                   ins;
  logic                   ram_we;
  logic [RW-1:0]          ram_waddr;
  logic [VAL_W-1:0]       ram_rdata;

  assign is_set     = (req_q.op == OP_SET);
  assign sts.is_get = (req_q.op == OP_GET);
  assign ins        = cmd.update && is_set && !hit_q && slot_found_q;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if ({3'b000, capacity} > MAX_W8) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign evict_c   = (count >= eff_cap);
  assign last_rank = RW'(count - CW'(1));
  assign free      = ~valid;
  assign free_oh   = free & (~free + MAX_ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_c[i] = valid[i] && (keys[i] == req_q.key);
      old_oh[i]  = valid[i] && (rank[i] == last_rank);
    end
  end

  assign slot_oh_c = evict_c ? old_oh : free_oh;

  always_comb begin
    hit_idx_c  = '0;
    hit_rank_c = '0;
    slot_idx_c = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx_c  = hit_idx_c | RW'(i);
        hit_rank_c = hit_rank_c | rank[i];
      end
      if (slot_oh_c[i]) begin
        slot_idx_c = slot_idx_c | RW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      valid    <= '0;
      count    <= '0;
      match    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      valid    <= '0;
      count    <= '0;
      match    <= '0;
    end else begin
      if (cmd.match) begin
        match <= match_c;
      end
      if (ins) begin
        valid <= valid | slot_oh_q;
        if (!evict_q) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && hit_q) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          rank[i] <= '0;
        end else if (valid[i] && (rank[i] < hit_rank_q)) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end else if (ins) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_oh_q[i]) begin
          rank[i] <= '0;
          keys[i] <= req_q.key;
        end else if (valid[i]) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.resolve) begin
      hit_q        <= |match;
      hit_idx_q    <= hit_idx_c;
      hit_rank_q   <= hit_rank_c;
      evict_q      <= evict_c;
      slot_oh_q    <= slot_oh_c;
      slot_idx_q   <= slot_idx_c;
      slot_found_q <= |slot_oh_c;
    end
    if (cmd.load_rsp) begin
      rsp.hit  <= hit_q;
      rsp.data <= hit_q ? ram_rdata : MISS_DATA;
    end
  end

  assign ram_we    = cmd.update && is_set && (hit_q || slot_found_q);
  assign ram_waddr = hit_q ? hit_idx_q : slot_idx_q;

  lkv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_q.value),
    .re    (cmd.resolve),
    .raddr (hit_idx_c),
    .rdata (ram_rdata)
  );

  `ASSERT_ALWAYS(a_count_valid, clk, rst, $countones(valid) == int'(count), "entry count off")
  `ASSERT_ALWAYS(a_unique_key, clk, rst, $onehot0(match), "key present in two entries")
  `ASSERT_IMPLIES(a_slot_found, clk, rst, cmd.update && is_set && !hit_q, slot_found_q, "no slot for insert")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and set requests through the request channel and checks every
// reply beat against a cycle-free model of the cache kept in this file.
// Capacity is rewritten between phases over APB, including the clamped
// values, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lkv_pkg::*;

  localparam int          NUM_SLOTS   = MAX_ENTRIES_DEF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          POOL_MAX    = 24;
  localparam int          DRAIN_WAIT  = 12;
  localparam logic [APB_AW-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] NO_REG_ADDR = 3'b100;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lru_key_value_cache i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // cache model state
  logic [KEY_W-1:0] slot_key  [NUM_SLOTS];
  logic [VAL_W-1:0] slot_val  [NUM_SLOTS];
  bit               slot_used [NUM_SLOTS];
  int unsigned      slot_rank [NUM_SLOTS];
  int unsigned      used_cnt;
  logic [CAP_W-1:0] cap_reg;

  req_t             req_q[$];
  rsp_t             reply_q[$];
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  int unsigned req_total = 0;
  int unsigned req_done  = 0;
  int unsigned rsp_seen  = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycles    = 0;
  bit          req_beat  = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void cache_clear();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    used_cnt = 0;
  endfunction

  function automatic int unsigned cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > NUM_SLOTS) return NUM_SLOTS;
    return cap_reg;
  endfunction

  // apply one request to the model; returns 1 when a reply beat follows
  function automatic bit cache_apply(input req_t r, output rsp_t reply);
    int          hit_idx;
    int          slot;
    bit          full;
    int unsigned old_rank;
    hit_idx = -1;
    reply   = '0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (hit_idx < 0 && slot_used[i] && slot_key[i] == r.key) hit_idx = i;
    if (hit_idx >= 0) begin
      if (r.op == OP_SET) slot_val[hit_idx] = r.value;
      old_rank = slot_rank[hit_idx];
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[hit_idx] = 0;
    end else if (r.op == OP_SET) begin
      full = used_cnt >= cap_limit();
      slot = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot < 0) begin
          if (full) begin
            if (slot_used[i] && slot_rank[i] + 1 == used_cnt) slot = i;
          end else if (!slot_used[i]) begin
            slot = i;
          end
        end
      end
      if (slot >= 0) begin
        if (full) slot_used[slot] = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_used[i]) slot_rank[i]++;
        slot_key[slot]  = r.key;
        slot_val[slot]  = r.value;
        slot_used[slot] = 1'b1;
        slot_rank[slot] = 0;
        if (!full) used_cnt++;
      end
    end
    if (r.op == OP_GET) begin
      reply.hit  = hit_idx >= 0;
      reply.data = (hit_idx >= 0) ? slot_val[hit_idx] : MISS_DATA;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_beat) begin
      // hold the beat until accepted
    end else if (gap_left > 0) begin
      req_valid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (req_q.size() > 0) begin
      req       <= req_q.pop_front();
      req_valid <= 1'b1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(24, 1);
        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_valid <= 1'b0;
    end
  end

  // reply receiver: stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rsp_seen >= 200) begin
      rsp_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2, 0);
        mode_left  <= $urandom_range(60, 5);
      end else begin
        mode_left <= mode_left - 1;
      end
      unique case (stall_mode)
        0: begin
          rsp_ready <= 1'b1;
        end
        1: begin
          rsp_ready <= 1'($urandom_range(1, 0));
        end
        default: begin
          rsp_ready <= ($urandom_range(3, 0) == 0);
        end
      endcase
    end
  end

  // monitor: predict on request beats, check reply beats
  always @(posedge clk) begin
    rsp_t want;
    req_beat <= !rst && req_valid && req_ready;
    if (!rst) begin
      if (req_valid && req_ready) begin
        req_done++;
        if (cache_apply(req, want)) reply_q.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("reply beat hit=%0b data=%h with nothing expected",
                                    rsp.hit, rsp.data));
        end else begin
          want = reply_q.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch($sformatf("reply %0d hit %b, expected %b",
                                      rsp_seen, rsp.hit, want.hit));
          if (rsp.data !== want.data)
            report_mismatch($sformatf("reply %0d data %h, expected %h",
                                      rsp_seen, rsp.data, want.data));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_key_value_cache: mismatch");
      $finish;
    end
  end

  task automatic push_req(input op_e op, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
    req_t r;
    r.op    = op;
    r.key   = k;
    r.value = v;
    req_q.push_back(r);
    req_total++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (req_done != req_total || reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic config_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] wdata);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b1, addr, wdata, rd);
    if (addr == CAP_ADDR) begin
      cap_reg = wdata[CAP_W-1:0];
      cache_clear();
      apb_xfer(1'b0, CAP_ADDR, '0, rd);
      if (rd !== APB_DW'(cap_reg))
        report_mismatch($sformatf("capacity reads %h, expected %h", rd, cap_reg));
    end
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned pool_n;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    pool_n = cap_limit() + 4;
    if (pool_n > POOL_MAX) pool_n = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    if ($urandom_range(1, 0)) key_pool[0] = 32'h8000_0000;
    if ($urandom_range(1, 0)) key_pool[1] = 32'h7fff_ffff;
    @(posedge clk);
    repeat (n_items) begin
      k = ($urandom_range(9, 0) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1, 0)];
      case ($urandom_range(7, 0))
        0: v = '1;
        1: v = '0;
        default: v = $urandom;
      endcase
      push_req($urandom_range(1, 0) ? OP_SET : OP_GET, k, v);
    end
    wait_drained();
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    logic [APB_DW-1:0] wdata;
    caps = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd7, 5'd3, 5'd17, 5'd16};
    caps[5] = CAP_W'($urandom_range(15, 2));
    cap_reg = CAP_RESET;
    cache_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: miss on empty, extremes, update in place
    @(posedge clk);
    push_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
    push_req(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    push_req(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    push_req(OP_SET, 32'h0000_0000, 32'hffff_ffff);
    push_req(OP_SET, 32'hffff_ffff, 32'h0000_0000);
    push_req(OP_GET, 32'h8000_0000, 32'h0);
    push_req(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(OP_GET, 32'h0000_0000, 32'h0);
    push_req(OP_GET, 32'hffff_ffff, 32'h0);
    push_req(OP_GET, 32'h0000_0005, 32'h0);
    push_req(OP_SET, 32'hffff_ffff, 32'h5a5a_a5a5);
    push_req(OP_GET, 32'hffff_ffff, 32'h0);
    wait_drained();

    // capacity two: promote then evict the least recent
    config_write(CAP_ADDR, 32'd2);
    @(posedge clk);
    push_req(OP_SET, 32'h0000_00a0, 32'h0000_0001);
    push_req(OP_SET, 32'h0000_00b0, 32'h0000_0002);
    push_req(OP_GET, 32'h0000_00a0, 32'h0);
    push_req(OP_SET, 32'h0000_00c0, 32'h0000_0003);
    push_req(OP_GET, 32'h0000_00b0, 32'h0);
    push_req(OP_GET, 32'h0000_00a0, 32'h0);
    push_req(OP_GET, 32'h0000_00c0, 32'h0);
    wait_drained();

    // capacity zero behaves as one
    config_write(CAP_ADDR, 32'd0);
    @(posedge clk);
    push_req(OP_SET, 32'h0000_0011, 32'h0000_0011);
    push_req(OP_SET, 32'h0000_0022, 32'h0000_0022);
    push_req(OP_GET, 32'h0000_0011, 32'h0);
    push_req(OP_GET, 32'h0000_0022, 32'h0);
    wait_drained();

    foreach (caps[i]) begin
      wdata = (i == 6) ? (($urandom & ~32'h1f) | caps[i]) : APB_DW'(caps[i]);
      config_write(CAP_ADDR, wdata);
      random_phase(130);
      if (i == 3) begin
        // no register here: store must survive
        config_write(NO_REG_ADDR, $urandom);
        random_phase(40);
      end
    end

    if (err_cnt == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lkv_pkg.sv
hdl/lkv_ram.sv
hdl/lkv_ctrl.sv
hdl/lkv_dpath.sv
hdl/lru_key_value_cache.sv
test/tb_top.sv
